[rtl/mtj_pkg.sv]
// Shared codes, command type and byte tables for the MSDP to JSON transcoder.
`default_nettype none
package mtj_pkg;

  localparam logic [7:0] B_IAC    = 8'd255;
  localparam logic [7:0] B_SB     = 8'd250;
  localparam logic [7:0] B_SE     = 8'd240;
  localparam logic [7:0] OPT_MSDP = 8'd69;
  localparam logic [7:0] OPT_GMCP = 8'd201;

  localparam logic [2:0] M_NONE   = 3'd0;
  localparam logic [2:0] M_VAR    = 3'd1;
  localparam logic [2:0] M_VAL    = 3'd2;
  localparam logic [2:0] M_TOPEN  = 3'd3;
  localparam logic [2:0] M_TCLOSE = 3'd4;
  localparam logic [2:0] M_AOPEN  = 3'd5;
  localparam logic [2:0] M_ACLOSE = 3'd6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // Output slots in emission order: header, pending quote, held IAC,
  // converted bytes, trailer.
  localparam int NSLOT = 17;
  localparam logic [4:0] S_HDR0  = 5'd0;
  localparam logic [4:0] S_QUOTE = 5'd9;
  localparam logic [4:0] S_IAC   = 5'd10;
  localparam logic [4:0] S_CONV0 = 5'd11;
  localparam logic [4:0] S_CONV1 = 5'd12;
  localparam logic [4:0] S_CONV2 = 5'd13;
  localparam logic [4:0] S_TRL0  = 5'd14;
  localparam logic [4:0] S_TRL1  = 5'd15;
  localparam logic [4:0] S_TRL2  = 5'd16;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [NSLOT-1:0] mask;
    logic [2:0][7:0]  conv;
  } cmd_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = B_IAC;
      4'd1:    r = B_SB;
      4'd2:    r = OPT_GMCP;
      4'd3:    r = 8'h4D;
      4'd4:    r = 8'h53;
      4'd5:    r = 8'h44;
      4'd6:    r = 8'h50;
      4'd7:    r = 8'h20;
      default: r = CH_LBRACE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] slot_byte(input logic [4:0] slot, input cmd_t c);
    logic [7:0] r;
    case (slot)
      S_QUOTE: r = CH_QUOTE;
      S_IAC:   r = B_IAC;
      S_CONV0: r = c.conv[0];
      S_CONV1: r = c.conv[1];
      S_CONV2: r = c.conv[2];
      S_TRL0:  r = CH_RBRACE;
      S_TRL1:  r = B_IAC;
      S_TRL2:  r = B_SE;
      default: r = hdr_byte(slot[3:0] - S_HDR0[3:0]);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/mtj_front.sv]
// Front end: frame state tracking and classification of each input byte into a command.
`default_nettype none
module mtj_front
  import mtj_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       frame_end,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       q_full,
  output logic            push,
  output cmd_t            cmd
);

  logic [1:0] byte_position, byte_position_next;
  logic [2:0] last_marker, last_marker_next;
  logic       quote_pending, quote_pending_next;
  logic       iac_held, iac_held_next;
  logic       stopped, stopped_next;

  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic       hdr, quote, iac_ff, trl, open_val;
    logic [1:0] n;
    logic [2:0][7:0] cv;
    hdr = 1'b0;
    quote = 1'b0;
    iac_ff = 1'b0;
    trl = 1'b0;
    n = 2'd0;
    cv = '0;
    open_val = (last_marker == M_VAL) || (last_marker == M_VAR);
    byte_position_next = byte_position;
    last_marker_next   = last_marker;
    quote_pending_next = quote_pending;
    iac_held_next      = iac_held;
    stopped_next       = stopped;

    if (!stopped) begin
      if (byte_position < 2'd2) begin
        byte_position_next = byte_position + 2'd1;
      end else if (byte_position == 2'd2) begin
        byte_position_next = 2'd3;
        hdr = (in_byte == OPT_MSDP);
      end else begin
        if (quote_pending) begin
          quote_pending_next = 1'b0;
          quote = (in_byte != {5'd0, M_TOPEN}) && (in_byte != {5'd0, M_AOPEN});
        end
        if (iac_held) begin
          iac_held_next = 1'b0;
          if (in_byte == B_SE) begin
            stopped_next = 1'b1;
            trl = 1'b1;
          end else begin
            iac_ff = 1'b1;
          end
        end
        if (!stopped_next) begin
          if (in_byte == B_IAC && !frame_end) begin
            iac_held_next = 1'b1;
          end else begin
            case (in_byte)
              {5'd0, M_TOPEN}: begin
                cv[0] = CH_LBRACE; n = 2'd1;
                last_marker_next = M_TOPEN;
              end
              {5'd0, M_TCLOSE}: begin
                if (open_val) begin
                  cv[0] = CH_QUOTE; cv[1] = CH_RBRACE; n = 2'd2;
                end else begin
                  cv[0] = CH_RBRACE; n = 2'd1;
                end
                last_marker_next = M_TCLOSE;
              end
              {5'd0, M_AOPEN}: begin
                cv[0] = CH_LBRACK; n = 2'd1;
                last_marker_next = M_AOPEN;
              end
              {5'd0, M_ACLOSE}: begin
                if (open_val) begin
                  cv[0] = CH_QUOTE; cv[1] = CH_RBRACK; n = 2'd2;
                end else begin
                  cv[0] = CH_RBRACK; n = 2'd1;
                end
                last_marker_next = M_ACLOSE;
              end
              {5'd0, M_VAR}: begin
                if (open_val) begin
                  cv[0] = CH_QUOTE; cv[1] = CH_COMMA; cv[2] = CH_QUOTE; n = 2'd3;
                end else if (last_marker == M_TCLOSE || last_marker == M_ACLOSE) begin
                  cv[0] = CH_COMMA; cv[1] = CH_QUOTE; n = 2'd2;
                end else begin
                  cv[0] = CH_QUOTE; n = 2'd1;
                end
                last_marker_next = M_VAR;
              end
              {5'd0, M_VAL}: begin
                if (last_marker == M_VAR) begin
                  cv[0] = CH_QUOTE; cv[1] = CH_COLON; n = 2'd2;
                end else if (last_marker == M_VAL) begin
                  cv[0] = CH_QUOTE; cv[1] = CH_COMMA; n = 2'd2;
                end
                last_marker_next = M_VAL;
                // value marker at frame end opens its quote right away
                if (frame_end) begin
                  cv[n] = CH_QUOTE;
                  n = n + 2'd1;
                end else begin
                  quote_pending_next = 1'b1;
                end
              end
              CH_BSLASH: begin
                cv[0] = CH_BSLASH; cv[1] = CH_BSLASH; n = 2'd2;
              end
              CH_QUOTE: begin
                cv[0] = CH_BSLASH; cv[1] = CH_QUOTE; n = 2'd2;
              end
              default: begin
                cv[0] = in_byte; n = 2'd1;
              end
            endcase
          end
        end
      end
    end

    if (frame_end) begin
      if (!stopped && !stopped_next) trl = 1'b1;
      byte_position_next = 2'd0;
      last_marker_next   = M_NONE;
      quote_pending_next = 1'b0;
      iac_held_next      = 1'b0;
      stopped_next       = 1'b0;
    end

    cmd.conv = cv;
    cmd.mask = {{3{trl}}, (n == 2'd3), (n > 2'd1), (n != 2'd0), iac_ff, quote, {9{hdr}}};
  end

  assign push = accept && (cmd.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 2'd0;
      last_marker   <= M_NONE;
      quote_pending <= 1'b0;
      iac_held      <= 1'b0;
      stopped       <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      last_marker   <= last_marker_next;
      quote_pending <= quote_pending_next;
      iac_held      <= iac_held_next;
      stopped       <= stopped_next;
    end
  end

endmodule
`default_nettype wire

[rtl/mtj_queue.sv]
// Short command queue between front and back ends.
`default_nettype none
module mtj_queue
  import mtj_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  cmd_t             mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QAW:0]     count;

  assign empty = (count == '0);
  assign full  = (count == QAW'(0) + (QAW+1)'(QDEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      case ({push, pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/mtj_back.sv]
// Back end: queued commands to output bytes, one per cycle unless stalled.
`default_nettype none
module mtj_back
  import mtj_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       head,
  input  wire logic       empty,
  output logic            pop,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            frame_last,
  output logic            out_valid,
  input  wire logic       out_ready
);

  logic             active;
  logic [NSLOT-1:0] pend;
  logic [NSLOT-1:0] cur_mask, rest;
  logic [4:0]       slot;
  logic             emit;

  assign cur_mask = active ? pend : head.mask;
  assign emit     = !empty && (!out_valid || out_ready);

  // lowest pending slot goes out first
  always_comb begin
    slot = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (cur_mask[i]) slot = 5'(i);
    end
  end

  assign rest = cur_mask & ~(NSLOT'(1) << slot);
  assign pop  = emit && (rest == '0);

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= slot_byte(slot, head);
      run_last   <= (rest == '0);
      frame_last <= (slot == S_TRL2);
      pend       <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active    <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        active    <= (rest != '0);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/msdp_to_json_transcoder_core.sv]
// The first output beat of an input byte goes through the command queue, then the back end's output register.
// Throughput: one input beat per cycle while the 4-entry command queue has room;
// output is one byte per cycle while not stalled, so a byte with k results gives k output beats.
// Bytes that yield no result never enter the queue.
// Reset: synchronous active-high rst clears frame state, queue and output valid.
// Top level: front end, command queue and byte-expanding back end.
`default_nettype none
module msdp_to_json_transcoder_core
  import mtj_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       frame_end,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            frame_last,
  output logic            out_valid,
  input  wire logic       out_ready
);

  cmd_t push_cmd, head;
  logic push, pop, empty, full;

  mtj_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .frame_end (frame_end),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_full    (full),
    .push      (push),
    .cmd       (push_cmd)
  );

  mtj_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  mtj_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_last (frame_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule
`default_nettype wire

[rtl/mtj_checker.sv]
// Port-level checker for the transcoder and its bind.
`default_nettype none
module mtj_checker
  import mtj_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic [7:0] in_byte,
  input wire logic       frame_end,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] out_byte,
  input wire logic       run_last,
  input wire logic       frame_last,
  input wire logic       out_valid,
  input wire logic       out_ready
);

  logic [7:0] prev_byte;

  // last byte taken on the output side
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte <= 8'h00;
    end else if (out_valid && out_ready) begin
      prev_byte <= out_byte;
    end
  end

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(run_last) && $stable(frame_last))
    else $error("output beat changed while stalled");

  // frame trailer SE ends the run of its input byte
  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> run_last && out_byte == B_SE)
    else $error("frame_last on a beat that is not the closing SE");

  // trailer SE is always preceded by IAC
  a_se_after_iac: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> prev_byte == B_IAC)
    else $error("closing SE not preceded by IAC");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind msdp_to_json_transcoder_core mtj_checker u_mtj_checker (.*);
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the MSDP to JSON transcoder core.
`timescale 1ns / 1ps
module testbench;
  import mtj_pkg::*;

  localparam logic [2:0] PREDICTED = 3'd7;  // row has no typed result, use the predictor
  localparam int RANDOM_ITEMS = 470;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       frm_end;
  } json_beat_t;

  typedef struct packed {
    logic [7:0]      b;
    logic            fe;
    logic [2:0]      nexp;
    logic [2:0][7:0] e;
    logic            fl;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] in_byte = 8'h00;
  logic       frame_end = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_last;
  logic       out_valid;
  logic       out_ready = 1'b0;

  stim_row_t  cur_row = '0;
  bit         calm_in = 1'b0;
  bit         calm_out = 1'b0;
  int         errors = 0;
  int         items_sent = 0;
  int         frames_sent = 0;
  int         beats_checked = 0;

  // transcoder state mirror
  logic [1:0] fr_pos = 2'd0;
  logic [2:0] last_mark = M_NONE;
  logic       quote_pend = 1'b0;
  logic       iac_pend = 1'b0;
  logic       halted = 1'b0;

  json_beat_t run_beats[$];
  json_beat_t json_want_q[$];

  msdp_to_json_transcoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .frame_end  (frame_end),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_last (frame_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("[%0t] mismatch: %s got 0x%02h want 0x%02h", $time, what, got, want);
  endtask

  function automatic void put_beat(input logic [7:0] ch, input logic fl);
    json_beat_t t;
    t.ch = ch;
    t.run_end = 1'b0;
    t.frm_end = fl;
    run_beats.push_back(t);
  endfunction

  function automatic void put_trailer();
    put_beat(CH_RBRACE, 1'b0);
    put_beat(B_IAC, 1'b0);
    put_beat(B_SE, 1'b1);
  endfunction

  // map one body byte to JSON text, driven by the last marker seen
  function automatic void json_convert(input logic [7:0] b, input logic at_end);
    logic [2:0] lm;
    logic       open_val;
    lm = last_mark;
    open_val = (lm == M_VAL) || (lm == M_VAR);
    if (b == M_TOPEN) begin
      put_beat(CH_LBRACE, 1'b0);
      last_mark = M_TOPEN;
    end else if (b == M_TCLOSE) begin
      if (open_val) put_beat(CH_QUOTE, 1'b0);
      put_beat(CH_RBRACE, 1'b0);
      last_mark = M_TCLOSE;
    end else if (b == M_AOPEN) begin
      put_beat(CH_LBRACK, 1'b0);
      last_mark = M_AOPEN;
    end else if (b == M_ACLOSE) begin
      if (open_val) put_beat(CH_QUOTE, 1'b0);
      put_beat(CH_RBRACK, 1'b0);
      last_mark = M_ACLOSE;
    end else if (b == M_VAR) begin
      if (open_val) put_beat(CH_QUOTE, 1'b0);
      if (open_val || lm == M_TCLOSE || lm == M_ACLOSE) put_beat(CH_COMMA, 1'b0);
      put_beat(CH_QUOTE, 1'b0);
      last_mark = M_VAR;
    end else if (b == M_VAL) begin
      if (lm == M_VAR) begin
        put_beat(CH_QUOTE, 1'b0);
        put_beat(CH_COLON, 1'b0);
      end
      if (lm == M_VAL) begin
        put_beat(CH_QUOTE, 1'b0);
        put_beat(CH_COMMA, 1'b0);
      end
      last_mark = M_VAL;
      if (at_end) put_beat(CH_QUOTE, 1'b0);
      else quote_pend = 1'b1;
    end else if (b == CH_BSLASH) begin
      put_beat(CH_BSLASH, 1'b0);
      put_beat(CH_BSLASH, 1'b0);
    end else if (b == CH_QUOTE) begin
      put_beat(CH_BSLASH, 1'b0);
      put_beat(CH_QUOTE, 1'b0);
    end else begin
      put_beat(b, 1'b0);
    end
  endfunction

  // expected output run for one accepted input byte, left in run_beats
  function automatic void transcode_byte(input logic [7:0] b, input logic fe);
    logic       was_halted;
    string      tag;
    json_beat_t t;
    tag = "MSDP {";
    was_halted = halted;
    run_beats.delete();
    if (!halted) begin
      if (fr_pos < 2'd2) begin
        fr_pos = fr_pos + 2'd1;
      end else if (fr_pos == 2'd2) begin
        fr_pos = 2'd3;
        if (b == OPT_MSDP) begin
          put_beat(B_IAC, 1'b0);
          put_beat(B_SB, 1'b0);
          put_beat(OPT_GMCP, 1'b0);
          for (int i = 0; i < tag.len(); i++) put_beat(tag[i], 1'b0);
        end
      end else begin
        // the quote after VAL is decided before this byte is handled
        if (quote_pend) begin
          quote_pend = 1'b0;
          if (b != M_TOPEN && b != M_AOPEN) put_beat(CH_QUOTE, 1'b0);
        end
        if (iac_pend) begin
          iac_pend = 1'b0;
          if (b == B_SE) begin
            halted = 1'b1;
            put_trailer();
          end else begin
            put_beat(B_IAC, 1'b0);
          end
        end
        if (!halted) begin
          if (b == B_IAC && !fe) iac_pend = 1'b1;
          else json_convert(b, fe);
        end
      end
    end
    if (fe) begin
      if (!was_halted && !halted) put_trailer();
      fr_pos = 2'd0;
      last_mark = M_NONE;
      quote_pend = 1'b0;
      iac_pend = 1'b0;
      halted = 1'b0;
    end
    if (run_beats.size() > 0) begin
      t = run_beats.pop_back();
      t.run_end = 1'b1;
      run_beats.push_back(t);
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    json_beat_t want;
    json_beat_t t;
    if (!rst) begin
      if (in_valid && in_ready) begin
        transcode_byte(in_byte, frame_end);
        if (cur_row.nexp == PREDICTED) begin
          foreach (run_beats[i]) json_want_q.push_back(run_beats[i]);
        end else begin
          for (int i = 0; i < int'(cur_row.nexp); i++) begin
            t.ch = cur_row.e[i];
            t.run_end = (i == int'(cur_row.nexp) - 1);
            t.frm_end = cur_row.fl && (i == int'(cur_row.nexp) - 1);
            json_want_q.push_back(t);
          end
        end
      end
      if (out_valid && out_ready) begin
        beats_checked++;
        if (json_want_q.size() == 0) begin
          report_mismatch("beat with nothing expected, out_byte", out_byte, 8'h00);
        end else begin
          want = json_want_q.pop_front();
          if (out_byte !== want.ch) report_mismatch("out_byte", out_byte, want.ch);
          if (run_last !== want.run_end)
            report_mismatch("run_last", {7'd0, run_last}, {7'd0, want.run_end});
          if (frame_last !== want.frm_end)
            report_mismatch("frame_last", {7'd0, frame_last}, {7'd0, want.frm_end});
        end
      end
    end
  end

  // output side backpressure
  initial begin : sink
    int stall;
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
    end
  end

  function automatic stim_row_t stim_row(input logic [7:0] b, input logic fe,
                                         input logic [2:0] nexp, input logic [7:0] e0,
                                         input logic [7:0] e1, input logic [7:0] e2,
                                         input logic fl);
    stim_row_t r;
    r.b = b;
    r.fe = fe;
    r.nexp = nexp;
    r.e = {e2, e1, e0};
    r.fl = fl;
    return r;
  endfunction

  task automatic send_beat(input stim_row_t r);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_byte <= r.b;
    frame_end <= r.fe;
    cur_row <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic [7:0] body_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'($urandom_range(1, 6));
    if (r < 50) return CH_BSLASH;
    if (r < 55) return CH_QUOTE;
    if (r < 61) return B_IAC;
    if (r < 64) return B_SE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_frame();
    stim_row_t rows[$];
    stim_row_t r;
    int        kind;
    int        len;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // noise
      len = $urandom_range(1, 8);
      repeat (len) rows.push_back(stim_row(8'($urandom_range(0, 255)), 1'b0, PREDICTED,
                                           8'h00, 8'h00, 8'h00, 1'b0));
    end else if (kind < 14) begin
      // cut short before the option byte
      len = $urandom_range(0, 1);
      repeat (len) rows.push_back(stim_row(B_IAC, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    end else begin
      rows.push_back(stim_row(B_IAC, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
      rows.push_back(stim_row(B_SB, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
      rows.push_back(stim_row(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                              : OPT_MSDP, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 14);
      repeat (len) rows.push_back(stim_row(body_byte(), 1'b0, PREDICTED,
                                           8'h00, 8'h00, 8'h00, 1'b0));
      if ($urandom_range(0, 1) == 1) begin
        rows.push_back(stim_row(B_IAC, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
        rows.push_back(stim_row(B_SE, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
        len = $urandom_range(0, 2);
        repeat (len) rows.push_back(stim_row(body_byte(), 1'b0, PREDICTED,
                                             8'h00, 8'h00, 8'h00, 1'b0));
      end
    end
    if (rows.size() == 0 || $urandom_range(0, 2) == 0)
      rows.push_back(stim_row(body_byte(), 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    r = rows.pop_back();
    r.fe = 1'b1;
    rows.push_back(r);
    calm_in = ($urandom_range(0, 4) == 0);
    foreach (rows[i]) send_beat(rows[i]);
    frames_sent++;
  endtask

  initial begin : stimulus
    stim_row_t dir_rows[$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // frame end before the option byte: trailer only
    dir_rows.push_back(stim_row(8'h41, 1'b1, 3'd3, CH_RBRACE, B_IAC, B_SE, 1'b1));
    // MSDP frame through every marker, escapes, held IAC, stop on IAC SE
    dir_rows.push_back(stim_row(B_IAC, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(B_SB, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(OPT_MSDP, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(M_TOPEN, 1'b0, 3'd1, CH_LBRACE, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(M_VAR, 1'b0, 3'd1, CH_QUOTE, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(8'h61, 1'b0, 3'd1, 8'h61, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(M_VAL, 1'b0, 3'd2, CH_QUOTE, CH_COLON, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(CH_BSLASH, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(CH_QUOTE, 1'b0, 3'd2, CH_BSLASH, CH_QUOTE, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(B_IAC, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(8'h41, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(M_TCLOSE, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(M_AOPEN, 1'b0, 3'd1, CH_LBRACK, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(M_VAL, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(M_AOPEN, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(M_ACLOSE, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(M_VAR, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(B_IAC, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(B_SE, 1'b0, 3'd3, CH_RBRACE, B_IAC, B_SE, 1'b1));
    // after a stop, bytes and the end byte are swallowed
    dir_rows.push_back(stim_row(8'h10, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(M_VAL, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    // other option: no header; VAL on the end byte opens a quote
    dir_rows.push_back(stim_row(B_IAC, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(B_SB, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(M_VAL, 1'b1, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    // IAC on the end byte passes through before the trailer
    dir_rows.push_back(stim_row(B_IAC, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(B_SB, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(OPT_MSDP, 1'b0, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(stim_row(B_IAC, 1'b1, PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0));

    foreach (dir_rows[i]) send_beat(dir_rows[i]);
    frames_sent += 4;

    while (items_sent < RANDOM_ITEMS) send_frame();
    in_valid <= 1'b0;

    // let the scoreboard see the last accepted beat, then drain
    @(posedge clk);
    while (json_want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d input beats in %0d frames; checked %0d output beats.",
             items_sent, frames_sent, beats_checked);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mtj_pkg.sv
rtl/mtj_front.sv
rtl/mtj_queue.sv
rtl/mtj_back.sv
rtl/msdp_to_json_transcoder_core.sv
rtl/mtj_checker.sv
dv/testbench.sv
